>>> rtl/core/wli_pkg.sv
// ----------------------------------------------------------------------------
// wli_pkg
// Shared types and constants for the windowed Lagrange interpolator.
// ----------------------------------------------------------------------------
package wli_pkg;

  localparam int unsigned DefTableDepth = 1024;
  localparam int unsigned DefMaxOrder   = 8;

  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_APPEND = 2'd1;
  localparam logic [1:0] OP_QUERY  = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_ORDER = 2'd2;
  localparam logic [1:0] ST_SAT   = 2'd3;

  typedef enum logic [4:0] {
    S_IDLE,
    S_SRCH,
    S_SCHK,
    S_POST,
    S_NRD,
    S_NCHK,
    S_YRD,
    S_YOUT,
    S_NODE_RD,
    S_NODE_CHK,
    S_TERM_RD,
    S_TERM_LD,
    S_FAC_RD,
    S_FAC_CHK,
    S_MUL,
    S_DIVI,
    S_DIV,
    S_DIVF,
    S_ACC,
    S_FIN,
    S_EMIT
  } state_e;

endpackage

>>> rtl/core/wli_ram.sv
// ----------------------------------------------------------------------------
// wli_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module wli_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

>>> rtl/core/windowed_lagrange_interpolator.sv
// ----------------------------------------------------------------------------
// windowed_lagrange_interpolator
// Sample table in two RAMs; queries search the table, then either pick the
// nearest sample or evaluate a Lagrange polynomial over a window of samples.
// ----------------------------------------------------------------------------
//  channel | signals                                  | role
//  in      | in_valid_i/in_ready_o, op, x_value, y    | clear, append, query
//  out     | out_valid_o/out_ready_i, y_result, status | one word per query
//  cfg     | cfg_we_i, cfg_wdata_i                    | window_order
//
// Clear and append complete in the idle state. A query scans the table entry by
// entry; nearest mode then compares the neighbouring samples. Interpolation checks
// the window for a node hit, then computes each factor by a read, a partial-product
// multiply and a restoring divide.
// Reset clears control state and the sample count; RAM contents are not
// cleared. A new word is accepted while a finished result waits on out.
// ----------------------------------------------------------------------------
module windowed_lagrange_interpolator #(
  parameter int unsigned TableDepth = wli_pkg::DefTableDepth,
  parameter int unsigned MaxOrder   = wli_pkg::DefMaxOrder
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         op_i,
  input  logic signed [31:0] x_value_i,
  input  logic signed [31:0] y_value_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] y_result_o,
  output logic [1:0]         status_o,
  input  logic               cfg_we_i,
  input  logic [3:0]         cfg_wdata_i
);

  import wli_pkg::*;

  localparam int unsigned AW  = $clog2(TableDepth);
  localparam int unsigned CW  = $clog2(TableDepth + 1);
  localparam int unsigned OW  = $clog2(MaxOrder + 1);
  localparam logic signed [63:0] Lim = 64'sh2000_0000_0000_0000;

  state_e state_q, state_d;

  logic [3:0]         order_q;
  logic [CW-1:0]      count_q, count_d;
  logic [CW-1:0]      b_q, b_d;
  logic [CW-1:0]      start_q, start_d;
  logic [CW-1:0]      pick_q, pick_d;
  logic [OW-1:0]      ord_q, ord_d;
  logic [OW-1:0]      ki_q, ki_d, kj_q, kj_d;
  logic signed [31:0] q_q, q_d, xb_q, xb_d, xi_q, xi_d;
  logic [61:0]        m_q, m_d;
  logic               neg_q, neg_d, flip_q, flip_d, sat_q, sat_d;
  logic [32:0]        bm_q, bm_d, dm_q, dm_d;
  logic [2:0]         pk_q, pk_d;
  logic [63:0]        pp_q, pp_d;
  logic [6:0]         sh_q, sh_d;
  logic [95:0]        prod_q, prod_d;
  logic [63:0]        lo_q, lo_d, quo_q, quo_d;
  logic [32:0]        rem_q, rem_d;
  logic [5:0]         dcnt_q, dcnt_d;
  logic signed [63:0] acc_q, acc_d;
  logic signed [31:0] res_y_q, res_y_d, out_y_q;
  logic [1:0]         res_st_q, res_st_d, out_st_q;
  logic               out_valid_q;

  logic               ram_we;
  logic [AW-1:0]      ram_raddr;
  logic [31:0]        x_rd, y_rd;

  logic               accept, emit, last_j;
  logic [OW-1:0]      ord_c;
  logic [CW-1:0]      half, start_c, nmo;
  logic signed [32:0] num, den, dlo, dhi;
  logic [32:0]        num_m, den_m, divt;
  logic               divge;
  logic signed [63:0] term, sum;

  wli_ram #(.Width(32), .Depth(TableDepth)) u_ram_x (
    .clk_i, .we_i(ram_we), .waddr_i(count_q[AW-1:0]), .wdata_i(x_value_i),
    .raddr_i(ram_raddr), .rdata_o(x_rd)
  );

  wli_ram #(.Width(32), .Depth(TableDepth)) u_ram_y (
    .clk_i, .we_i(ram_we), .waddr_i(count_q[AW-1:0]), .wdata_i(y_value_i),
    .raddr_i(ram_raddr), .rdata_o(y_rd)
  );

  assign in_ready_o  = (state_q == S_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign emit        = (state_q == S_EMIT) && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;
  assign y_result_o  = out_y_q;
  assign status_o    = out_st_q;
  assign ram_we      = accept && (op_i == OP_APPEND) && (count_q < CW'(TableDepth));

  // window bounds
  assign ord_c   = (32'(order_q) > 32'(MaxOrder)) ? OW'(MaxOrder) : OW'(order_q);
  assign half    = CW'(ord_q >> 1);
  assign nmo     = count_q - CW'(ord_q);
  assign start_c = ((b_q >= half) ? (b_q - half) : '0) > nmo ? nmo
                 : ((b_q >= half) ? (b_q - half) : '0);
  assign last_j  = (kj_q == ord_q - OW'(1));

  assign num   = {q_q[31], q_q} - {x_rd[31], x_rd};
  assign den   = {xi_q[31], xi_q} - {x_rd[31], x_rd};
  assign num_m = num[32] ? 33'(-num) : 33'(num);
  assign den_m = den[32] ? 33'(-den) : 33'(den);
  assign dlo   = {q_q[31], q_q} - {x_rd[31], x_rd};
  assign dhi   = {xb_q[31], xb_q} - {q_q[31], q_q};
  assign divt  = {rem_q[31:0], lo_q[63]};
  assign divge = (divt >= dm_q);
  assign term  = neg_q ? -$signed({2'b00, m_q}) : $signed({2'b00, m_q});
  assign sum   = acc_q + term;

  // read address
  always_comb begin
    case (state_q)
      S_SRCH:    ram_raddr = b_q[AW-1:0];
      S_NRD:     ram_raddr = AW'(b_q - CW'(1));
      S_YRD:     ram_raddr = pick_q[AW-1:0];
      S_NODE_RD: ram_raddr = AW'(start_q + CW'(kj_q));
      S_TERM_RD: ram_raddr = AW'(start_q + CW'(ki_q));
      S_FAC_RD:  ram_raddr = AW'(start_q + CW'(kj_q));
      default:   ram_raddr = '0;
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept && op_i == OP_QUERY) begin
          state_d = (count_q == '0) ? S_EMIT : S_SRCH;
        end
      end
      S_SRCH: state_d = S_SCHK;
      S_SCHK: begin
        if ($signed(x_rd) < q_q && b_q + CW'(1) != count_q) state_d = S_SRCH;
        else state_d = S_POST;
      end
      S_POST: begin
        if (order_q == '0) begin
          state_d = (b_q >= count_q || b_q == '0) ? S_YRD : S_NRD;
        end else if (CW'(ord_q) > count_q) begin
          state_d = S_EMIT;
        end else begin
          state_d = S_NODE_RD;
        end
      end
      S_NRD:      state_d = S_NCHK;
      S_NCHK:     state_d = S_YRD;
      S_YRD:      state_d = S_YOUT;
      S_YOUT:     state_d = S_EMIT;
      S_NODE_RD:  state_d = S_NODE_CHK;
      S_NODE_CHK: begin
        if ($signed(x_rd) == q_q) state_d = S_YRD;
        else if (last_j) state_d = S_TERM_RD;
        else state_d = S_NODE_RD;
      end
      S_TERM_RD: state_d = S_TERM_LD;
      S_TERM_LD: state_d = S_FAC_RD;
      S_FAC_RD:  state_d = S_FAC_CHK;
      S_FAC_CHK: begin
        if (kj_q == ki_q || den == '0) state_d = last_j ? S_ACC : S_FAC_RD;
        else state_d = S_MUL;
      end
      S_MUL:  state_d = (pk_q == 3'd4) ? S_DIVI : S_MUL;
      S_DIVI: begin
        if (prod_q[95:64] >= dm_q) state_d = last_j ? S_ACC : S_FAC_RD;
        else state_d = S_DIV;
      end
      S_DIV:  state_d = (dcnt_q == 6'd63) ? S_DIVF : S_DIV;
      S_DIVF: state_d = last_j ? S_ACC : S_FAC_RD;
      S_ACC:  state_d = (ki_q == ord_q - OW'(1)) ? S_FIN : S_TERM_RD;
      S_FIN:  state_d = S_EMIT;
      S_EMIT: state_d = emit ? S_IDLE : S_EMIT;
      default: state_d = S_IDLE;
    endcase
  end

  // datapath
  always_comb begin
    count_d = count_q;  b_d = b_q;  start_d = start_q;  pick_d = pick_q;
    ord_d = ord_q;  ki_d = ki_q;  kj_d = kj_q;  q_d = q_q;  xb_d = xb_q;
    xi_d = xi_q;  m_d = m_q;  neg_d = neg_q;  flip_d = flip_q;  sat_d = sat_q;
    bm_d = bm_q;  dm_d = dm_q;  pk_d = pk_q;  pp_d = pp_q;  sh_d = sh_q;
    prod_d = prod_q;  lo_d = lo_q;  quo_d = quo_q;  rem_d = rem_q;
    dcnt_d = dcnt_q;  acc_d = acc_q;  res_y_d = res_y_q;  res_st_d = res_st_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (op_i)
            OP_CLEAR:  count_d = '0;
            OP_APPEND: if (ram_we) count_d = count_q + CW'(1);
            OP_QUERY: begin
              q_d = x_value_i;  b_d = '0;  acc_d = '0;  sat_d = 1'b0;
              ord_d = ord_c;  res_y_d = '0;
              res_st_d = (count_q == '0) ? ST_EMPTY : ST_OK;
            end
            default: ;
          endcase
        end
      end
      S_SCHK: begin
        xb_d = x_rd;
        if ($signed(x_rd) < q_q) b_d = b_q + CW'(1);
      end
      S_POST: begin
        kj_d = '0;  ki_d = '0;  start_d = start_c;
        if (b_q >= count_q) pick_d = count_q - CW'(1);
        else pick_d = b_q;
        if (order_q != '0 && CW'(ord_q) > count_q) res_st_d = ST_ORDER;
      end
      S_NCHK: if (dlo < dhi) pick_d = b_q - CW'(1);
      S_YOUT: begin
        res_y_d = y_rd;  res_st_d = ST_OK;
      end
      S_NODE_CHK: begin
        pick_d = start_q + CW'(kj_q);
        kj_d = last_j ? '0 : kj_q + OW'(1);
      end
      S_TERM_LD: begin
        xi_d = x_rd;  neg_d = y_rd[31];
        // 32-bit negate gives the magnitude, 2^31 included
        m_d = {30'd0, (y_rd[31] ? 32'(-y_rd) : y_rd)};
        kj_d = '0;
      end
      S_FAC_CHK: begin
        bm_d = num_m;  dm_d = den_m;  flip_d = num[32] != den[32];
        pk_d = '0;  prod_d = '0;
        if (kj_q == ki_q || den == '0) kj_d = kj_q + OW'(1);
      end
      S_MUL: begin
        // partial products of m by the numerator magnitude, one per cycle
        case (pk_q)
          3'd0: begin pp_d = 64'(m_q[31:0]) * 64'(bm_q[31:0]); sh_d = 7'd0;  end
          3'd1: begin pp_d = 64'(m_q[61:32]) * 64'(bm_q[31:0]); sh_d = 7'd32; end
          3'd2: begin pp_d = 64'(m_q[31:0]) * 64'(bm_q[32]); sh_d = 7'd32; end
          3'd3: begin pp_d = 64'(m_q[61:32]) * 64'(bm_q[32]); sh_d = 7'd64; end
          default: pp_d = '0;
        endcase
        if (pk_q != '0) prod_d = prod_q + ({32'd0, pp_q} << sh_q);
        pk_d = pk_q + 3'd1;
      end
      S_DIVI: begin
        lo_d = prod_q[63:0];  rem_d = {1'b0, prod_q[95:64]};
        quo_d = '0;  dcnt_d = '0;
        if (prod_q[95:64] >= dm_q) begin
          m_d = 62'h2000_0000_0000_0000;  sat_d = 1'b1;
          neg_d = neg_q ^ flip_q;  kj_d = kj_q + OW'(1);
        end
      end
      S_DIV: begin
        rem_d = divge ? divt - dm_q : divt;
        quo_d = {quo_q[62:0], divge};
        lo_d = {lo_q[62:0], 1'b0};
        dcnt_d = dcnt_q + 6'd1;
      end
      S_DIVF: begin
        neg_d = neg_q ^ flip_q;  kj_d = kj_q + OW'(1);
        if (|quo_q[63:61]) begin
          m_d = 62'h2000_0000_0000_0000;  sat_d = 1'b1;
        end else begin
          m_d = quo_q[61:0] + 62'({rem_q, 1'b0} >= {1'b0, dm_q});
        end
      end
      S_ACC: begin
        ki_d = ki_q + OW'(1);
        if (sum > Lim) begin
          acc_d = Lim;  sat_d = 1'b1;
        end else if (sum < -Lim) begin
          acc_d = -Lim;  sat_d = 1'b1;
        end else begin
          acc_d = sum;
        end
      end
      S_FIN: begin
        res_st_d = sat_q ? ST_SAT : ST_OK;
        if (acc_q > 64'sd2147483647) begin
          res_y_d = 32'sh7fff_ffff;  res_st_d = ST_SAT;
        end else if (acc_q < -64'sd2147483648) begin
          res_y_d = 32'sh8000_0000;  res_st_d = ST_SAT;
        end else begin
          res_y_d = acc_q[31:0];
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      order_q     <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      if (cfg_we_i) order_q <= cfg_wdata_i;
      if (emit) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    b_q <= b_d;  start_q <= start_d;  pick_q <= pick_d;  ord_q <= ord_d;
    ki_q <= ki_d;  kj_q <= kj_d;  q_q <= q_d;  xb_q <= xb_d;  xi_q <= xi_d;
    m_q <= m_d;  neg_q <= neg_d;  flip_q <= flip_d;  sat_q <= sat_d;
    bm_q <= bm_d;  dm_q <= dm_d;  pk_q <= pk_d;  pp_q <= pp_d;  sh_q <= sh_d;
    prod_q <= prod_d;  lo_q <= lo_d;  quo_q <= quo_d;  rem_q <= rem_d;
    dcnt_q <= dcnt_d;  acc_q <= acc_d;  res_y_q <= res_y_d;
    res_st_q <= res_st_d;
    if (emit) begin
      out_y_q  <= res_y_q;
      out_st_q <= res_st_q;
    end
  end

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for windowed_lagrange_interpolator: drives clear, append
// and query words, predicts each query answer in a local model of the table,
// and compares every result word against the oldest outstanding answer.
// ----------------------------------------------------------------------------
module testbench;
  import wli_pkg::*;

  localparam int unsigned Depth      = 1024;
  localparam int unsigned OrderCap   = 8;
  localparam int unsigned CycleLimit = 3000000;
  localparam logic [63:0] MagLimit   = 64'd1 << 61;
  localparam logic [1:0]  OpUnused   = 2'd3;

  typedef struct packed {
    logic signed [31:0] y;
    logic [1:0]         st;
  } answer_t;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               in_valid    = 1'b0;
  logic [1:0]         op          = OP_CLEAR;
  logic signed [31:0] x_val       = '0;
  logic signed [31:0] y_val       = '0;
  logic               out_ready   = 1'b0;
  logic               cfg_we      = 1'b0;
  logic [3:0]         cfg_wdata   = '0;
  logic               in_ready_o;
  logic               out_valid_o;
  logic signed [31:0] y_result_o;
  logic [1:0]         status_o;

  // local copy of the table and register
  logic signed [31:0] tbl_x [Depth];
  logic signed [31:0] tbl_y [Depth];
  int unsigned        tbl_count;
  logic [3:0]         order_reg;

  answer_t            pending_answers [$];
  answer_t            want;
  int unsigned        mism_count;
  int unsigned        cycles;
  int unsigned        snd_idle;
  int unsigned        rcv_idle;

  windowed_lagrange_interpolator uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready_o),
    .op_i        (op),
    .x_value_i   (x_val),
    .y_value_i   (y_val),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready),
    .y_result_o  (y_result_o),
    .status_o    (status_o),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [63:0] abs64(longint v);
    return v < 0 ? 64'(-v) : 64'(v);
  endfunction

  // round(a*b/d) on magnitudes, halves away from zero, capped at 2^61
  function automatic logic [63:0] scale_ratio(logic [63:0] a, logic [63:0] b,
                                              logic [63:0] d, inout bit sat);
    logic [127:0] prod, quot, rem;
    prod = {64'd0, a} * {64'd0, b};
    quot = prod / {64'd0, d};
    rem  = prod % {64'd0, d};
    if (quot >= {64'd0, MagLimit}) begin
      sat = 1'b1;
      return MagLimit;
    end
    if (2 * rem >= {64'd0, d}) quot = quot + 1;
    return quot[63:0];
  endfunction

  function automatic longint clamp_sum(longint v, inout bit sat);
    if (v > longint'(MagLimit)) begin
      sat = 1'b1;
      return longint'(MagLimit);
    end
    if (v < -longint'(MagLimit)) begin
      sat = 1'b1;
      return -longint'(MagLimit);
    end
    return v;
  endfunction

  function automatic answer_t interpolate(logic signed [31:0] q);
    answer_t     a;
    int unsigned n, b, ord, start, pick;
    longint      acc, num, den, term, dlo, dhi;
    logic [63:0] m;
    bit          neg, sat;
    a = '{y: '0, st: ST_OK};
    n = tbl_count;
    b = 0;
    ord = order_reg;
    acc = 0;
    sat = 1'b0;
    if (n == 0) begin
      a.st = ST_EMPTY;
      return a;
    end
    while (b < n && tbl_x[b] < q) b++;
    if (ord == 0) begin
      if (b >= n) pick = n - 1;
      else if (b == 0) pick = 0;
      else begin
        dlo = longint'(q) - longint'(tbl_x[b-1]);
        dhi = longint'(tbl_x[b]) - longint'(q);
        pick = (dlo < dhi) ? b - 1 : b;
      end
      a.y = tbl_y[pick];
      return a;
    end
    if (ord > OrderCap) ord = OrderCap;
    if (ord > n) begin
      a.st = ST_ORDER;
      return a;
    end
    start = (b >= ord / 2) ? b - ord / 2 : 0;
    if (start > n - ord) start = n - ord;
    for (int unsigned i = start; i < start + ord; i++) begin
      if (tbl_x[i] == q) begin
        a.y = tbl_y[i];
        return a;
      end
    end
    for (int unsigned i = start; i < start + ord; i++) begin
      m   = abs64(longint'(tbl_y[i]));
      neg = tbl_y[i] < 0;
      for (int unsigned j = start; j < start + ord; j++) begin
        num = longint'(q) - longint'(tbl_x[j]);
        den = longint'(tbl_x[i]) - longint'(tbl_x[j]);
        if (j != i && den != 0) begin
          m = scale_ratio(m, abs64(num), abs64(den), sat);
          if ((num < 0) != (den < 0)) neg = !neg;
        end
      end
      term = neg ? -longint'(m) : longint'(m);
      acc  = clamp_sum(acc + term, sat);
    end
    if (acc > 64'sd2147483647) begin
      acc = 64'sd2147483647;
      sat = 1'b1;
    end
    if (acc < -64'sd2147483648) begin
      acc = -64'sd2147483648;
      sat = 1'b1;
    end
    a.y  = acc[31:0];
    a.st = sat ? ST_SAT : ST_OK;
    return a;
  endfunction

  function automatic void apply_word(logic [1:0] o, logic signed [31:0] x,
                                     logic signed [31:0] y);
    case (o)
      OP_CLEAR: tbl_count = 0;
      OP_APPEND: begin
        if (tbl_count < Depth) begin
          tbl_x[tbl_count] = x;
          tbl_y[tbl_count] = y;
          tbl_count++;
        end
      end
      OP_QUERY: pending_answers = {pending_answers, interpolate(x)};
      default: ;
    endcase
  endfunction

  // valid is left high after acceptance; the next call replaces the word, or an idle gap or drain() drops it
  task automatic send_word(logic [1:0] o, logic signed [31:0] x, logic signed [31:0] y);
    if ($urandom_range(99) < snd_idle) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < snd_idle) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    op       <= o;
    x_val    <= x;
    y_val    <= y;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    apply_word(o, x, y);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending_answers.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic set_order(logic [3:0] v);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk_i);
    order_reg = v;
    cfg_we <= 1'b0;
  endtask

  task automatic load_points(int unsigned k, logic signed [31:0] x0, int step,
                             logic signed [31:0] y0, int dy);
    for (int unsigned i = 0; i < k; i++)
      send_word(OP_APPEND, x0 + i * step, y0 + i * dy);
  endtask

  task automatic test_empty_and_order();
    send_word(OP_QUERY, 32'sd0, 32'sd0);
    set_order(4'd3);
    send_word(OP_QUERY, 32'h7fffffff, 32'sd0);
    load_points(2, 32'sh10000, 32'sh10000, 32'sh0, 32'sh20000);
    send_word(OP_QUERY, 32'sh18000, 32'sd0);         // order above count
    send_word(OpUnused, 32'sh18000, 32'sd5);         // ignored
    send_word(OP_CLEAR, 32'sd0, 32'sd0);
    send_word(OP_QUERY, 32'sd0, 32'sd0);
  endtask

  task automatic test_nearest();
    set_order(4'd0);
    load_points(3, 32'sh10000, 32'sh20000, 32'sh50000, 32'sh10000);
    send_word(OP_QUERY, 32'h80000000, 32'sd0);       // below first
    send_word(OP_QUERY, 32'sh20000, 32'sd0);         // tie goes high
    send_word(OP_QUERY, 32'sh1ffff, 32'sd0);
    send_word(OP_QUERY, 32'sh30000, 32'sd0);         // on node
    send_word(OP_QUERY, 32'h7fffffff, 32'sd0);       // past the end
  endtask

  task automatic test_lagrange();
    set_order(4'd3);
    send_word(OP_QUERY, 32'sh28000, 32'sd0);
    send_word(OP_QUERY, 32'sh50000, 32'sd0);         // on node, clamped window
    send_word(OP_QUERY, 32'sh7ffffff, 32'sd0);
    send_word(OP_CLEAR, 32'sd0, 32'sd0);
    send_word(OP_APPEND, 32'h80000000, 32'h7fffffff);
    send_word(OP_APPEND, 32'h80000001, 32'h80000000);
    send_word(OP_APPEND, 32'h80000001, 32'h7fffffff); // duplicate x
    send_word(OP_APPEND, 32'h7fffffff, 32'h80000000);
    set_order(4'd15);                                 // capped at eight
    send_word(OP_QUERY, 32'sh0, 32'sd0);
    set_order(4'd4);
    send_word(OP_QUERY, 32'h40000000, 32'sd0);        // saturates
    set_order(4'd8);
    send_word(OP_QUERY, 32'h7ffffffe, 32'sd0);
  endtask

  task automatic test_full_table();
    set_order(4'd2);
    send_word(OP_CLEAR, 32'sd0, 32'sd0);
    load_points(Depth + 1, -32'sd5000000, 32'sd9000, 32'sd77, -32'sd131);
    send_word(OP_QUERY, 32'h7fffffff, 32'sd0);
    send_word(OP_QUERY, -32'sd4995500, 32'sd0);
  endtask

  task automatic test_random(int unsigned words);
    int unsigned        sent, k;
    logic signed [31:0] x, y;
    int                 step;
    sent = 0;
    while (sent < words) begin
      if ($urandom_range(3) == 0) set_order(4'($urandom_range(15)));
      send_word(OP_CLEAR, $urandom, $urandom);
      k = $urandom_range(1, 12);
      x = ($urandom_range(3) == 0) ? $urandom
        : 32'($signed($urandom_range(0, 32'h3fffff)) - 32'sh200000);
      step = $urandom_range(1) ? $urandom_range(0, 32'h30000) : $urandom_range(0, 32'h4000000);
      for (int unsigned i = 0; i < k; i++) begin
        y = $urandom_range(3) == 0 ? $urandom
          : 32'($signed($urandom_range(0, 32'h1ffffff)) - 32'sh1000000);
        if ($urandom_range(15) == 0) send_word(OP_APPEND, $urandom, $urandom);  // out of order
        else send_word(OP_APPEND, x, y);
        x = (x > 32'sh7fffffff - step) ? x : x + $urandom_range(0, step);
        sent++;
      end
      repeat ($urandom_range(1, 5)) begin
        if ($urandom_range(9) == 0) send_word(OpUnused, $urandom, $urandom);
        else if ($urandom_range(4) == 0) send_word(OP_QUERY, $urandom, $urandom);
        else send_word(OP_QUERY, x - $urandom_range(0, k * step + 32'h20000), $urandom);
        sent++;
      end
    end
  endtask

  always @(posedge clk_i) begin
    out_ready <= ($urandom_range(99) >= rcv_idle);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready) begin
      if (pending_answers.size() == 0) begin
        mism_count++;
        if (mism_count <= 10)
          $display("unexpected result word: y %h status %0d", y_result_o, status_o);
      end else begin
        want = pending_answers.pop_front();
        if (want.y !== y_result_o || want.st !== status_o) begin
          mism_count++;
          if (mism_count <= 10)
            $display("mismatch: expected y %h status %0d, got y %h status %0d",
                     want.y, want.st, y_result_o, status_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    tbl_count  = 0;
    order_reg  = '0;
    mism_count = 0;
    cycles     = 0;
    snd_idle   = 30;
    rcv_idle   = 87;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_and_order();
    test_nearest();
    test_lagrange();
    test_full_table();
    test_random(150);
    snd_idle = 87;
    rcv_idle = 30;
    test_random(150);
    snd_idle = 0;
    rcv_idle = 0;
    test_random(150);
    drain();
    if (mism_count == 0 && pending_answers.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
